>>> rtl/mbps_pkg.sv
// Shared constants, types and helpers for the masked byte pattern search.
// Used by the stream interfaces, the window cell and the top level.
package mbps_pkg;

  // Pattern geometry
  localparam int MAX_PATTERN = 16;
  localparam int WIN_DEPTH   = MAX_PATTERN - 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
  localparam int PAT_W       = 8 * MAX_PATTERN;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int POS_W  = 32;
  localparam int CNT_W  = 16;
  localparam int CARE_W = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OCCURRENCE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET   = 3'd5;

  // Register reset values
  localparam logic [CARE_W-1:0] CARE_RESET = '1;
  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(1);
  localparam logic [CNT_W-1:0]  OCC_RESET  = CNT_W'(1);

  // Control shared by every window cell
  typedef struct packed {
    logic shift;  // accepted byte, window moves by one
    logic clear;  // final byte of region, window returns to zeros
  } cell_ctrl_t;

  // One masked compare: a wildcard or inactive position always passes
  function automatic logic byte_ok(input logic [BYTE_W-1:0] data,
                                   input logic [BYTE_W-1:0] pat,
                                   input logic              care);
    return !care || (data == pat);
  endfunction

endpackage

>>> rtl/mbps_in_if.sv
// Input stream channel: one region byte per beat plus the end-of-region flag.
// Depends on mbps_pkg for field widths.
interface mbps_in_if;
  logic                          valid;
  logic                          ready;
  logic [mbps_pkg::BYTE_W-1:0]   data_byte;
  logic                          region_last;

  modport source (output valid, output data_byte, output region_last, input ready);
  modport sink   (input valid, input data_byte, input region_last, output ready);
endinterface

>>> rtl/mbps_out_if.sv
// Result channel: found flag and start offset of the reported match.
// Depends on mbps_pkg for field widths.
interface mbps_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [mbps_pkg::POS_W-1:0]  match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

>>> rtl/mbps_cell.sv
// One stage of the byte window: holds a past region byte, passes it on,
// and compares it against the pattern byte aligned to it. Uses mbps_pkg.
module mbps_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mbps_pkg::cell_ctrl_t        ctrl_i,
  input  logic [mbps_pkg::BYTE_W-1:0] byte_i,
  input  logic [mbps_pkg::BYTE_W-1:0] pat_byte_i,
  input  logic                        care_i,
  output logic [mbps_pkg::BYTE_W-1:0] byte_o,
  output logic                        hit_o
);
  import mbps_pkg::*;

  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] byte_d;

  // Window byte: cleared at region end, shifted from the neighbor on any other accepted byte
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = '0;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;
  assign hit_o  = byte_ok(byte_q, pat_byte_i, care_i);

endmodule

>>> rtl/masked_byte_pattern_search_unit.sv
// Masked byte pattern search. Takes one region byte per cycle and reports, one
// beat per region, either the start offset of the requested (nth, overlapping)
// masked match or not-found when the region ends first. A byte is taken every
// cycle while the result register is empty or being drained; the result
// appears on the output in the cycle after the byte that decides it. The row of
// window cells compares all pattern positions against the newest bytes at
// once, combinationally, which sets the one-byte-per-cycle rate. Configuration
// is to be written only while the block is idle; the block does not enforce it.
module masked_byte_pattern_search_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  mbps_in_if.sink                         in_i,
  mbps_out_if.source                      out_o
);
  import mbps_pkg::*;

  // Configuration registers
  logic [CFG_DATA_W-1:0] pat_lo_q;
  logic [CFG_DATA_W-1:0] pat_hi_q;
  logic [CARE_W-1:0]     care_q;
  logic [LEN_W-1:0]      len_q;
  logic [CNT_W-1:0]      occ_q;
  logic [POS_W-1:0]      start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= CARE_RESET;
      len_q    <= LEN_RESET;
      occ_q    <= OCC_RESET;
      start_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PATTERN_LOW:    pat_lo_q <= cfg_wdata_i;
        CFG_PATTERN_HIGH:   pat_hi_q <= cfg_wdata_i;
        CFG_CARE_MASK:      care_q   <= cfg_wdata_i[CARE_W-1:0];
        CFG_PATTERN_LENGTH: len_q    <= cfg_wdata_i[LEN_W-1:0];
        CFG_OCCURRENCE:     occ_q    <= cfg_wdata_i[CNT_W-1:0];
        CFG_START_OFFSET:   start_q  <= cfg_wdata_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective length and occurrence (zero means one, length saturates)
  logic [LEN_W-1:0] len_eff;
  logic [CNT_W-1:0] want_eff;

  always_comb begin
    priority if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_q > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = len_q;
    end
  end

  assign want_eff = (occ_q == '0) ? CNT_W'(1) : occ_q;

  // Pattern bytes, byte 0 in the low bits
  logic [2*CFG_DATA_W-1:0] pat_all;
  logic [BYTE_W-1:0]       pat_bytes [MAX_PATTERN];

  assign pat_all = {pat_hi_q, pat_lo_q};

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pat_bytes[k] = pat_all[BYTE_W*k +: BYTE_W];
    end
  end

  // Handshake
  logic       out_valid_q;
  logic       in_fire;
  logic       out_fire;
  cell_ctrl_t cell_ctrl;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  assign cell_ctrl.shift = in_fire && !in_i.region_last;
  assign cell_ctrl.clear = in_fire && in_i.region_last;

  // Newest byte: pattern position len-1 lines up with the incoming byte
  logic [LEN_W-1:0] cur_k;
  logic             cur_hit;

  assign cur_k   = len_eff - LEN_W'(1);
  assign cur_hit = byte_ok(in_i.data_byte, pat_bytes[cur_k[PAT_IDX_W-1:0]],
                           care_q[cur_k[PAT_IDX_W-1:0]]);

  // Row of window cells; cell g holds the byte g+1 positions back
  logic [BYTE_W-1:0] win_byte [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] cell_hit;

  for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_cell
    localparam logic [LEN_W-1:0] Back = LEN_W'(g + 1);

    logic [LEN_W-1:0]  pat_k;
    logic              active;
    logic [BYTE_W-1:0] nbr_byte;

    assign pat_k  = len_eff - Back - LEN_W'(1);
    assign active = Back < len_eff;

    if (g == 0) begin : g_head
      assign nbr_byte = in_i.data_byte;
    end else begin : g_body
      assign nbr_byte = win_byte[g-1];
    end

    mbps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .byte_i     (nbr_byte),
      .pat_byte_i (pat_bytes[pat_k[PAT_IDX_W-1:0]]),
      .care_i     (active && care_q[pat_k[PAT_IDX_W-1:0]]),
      .byte_o     (win_byte[g]),
      .hit_o      (cell_hit[g])
    );
  end

  // Scan state
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] seen_q, seen_d;
  logic             done_q, done_d;

  logic [POS_W-1:0] start_pos;
  logic [CNT_W-1:0] seen_inc;
  logic             cand;
  logic             hit_req;
  logic             res_load;

  assign start_pos = pos_q - POS_W'(cur_k);
  assign seen_inc  = seen_q + CNT_W'(1);
  assign cand      = !done_q && (pos_q >= POS_W'(cur_k)) && (start_pos >= start_q)
                     && cur_hit && (&cell_hit);
  assign hit_req   = cand && (seen_inc == want_eff);
  assign res_load  = in_fire && (hit_req || (in_i.region_last && !done_q));

  always_comb begin
    pos_d  = pos_q;
    seen_d = seen_q;
    done_d = done_q;
    if (in_fire) begin
      if (cand) begin
        seen_d = seen_inc;
      end
      if (hit_req) begin
        done_d = 1'b1;
      end
      if (in_i.region_last) begin
        pos_d  = '0;
        seen_d = '0;
        done_d = 1'b0;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      seen_q <= '0;
      done_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      seen_q <= seen_d;
      done_q <= done_d;
    end
  end

  // Result register
  logic             out_valid_d;
  logic             found_q;
  logic [POS_W-1:0] offset_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      found_q  <= hit_req;
      offset_q <= hit_req ? start_pos : '0;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = found_q;
  assign out_o.match_offset = offset_q;

  // Checks
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.region_last |=> (pos_q == '0) && (seen_q == '0) && !done_q)
    else $error("region end did not clear the scan state");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !found_q |-> offset_q == '0)
    else $error("not-found result carries a nonzero offset");

  a_hit_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && found_q |-> offset_q >= start_q)
    else $error("reported match begins before the start offset");

endmodule
